FILE: hdl/indexed_insert_remove_list_unit_macros.svh
// Assertion macros for the indexed insert/remove list unit checker.
// Used by indexed_insert_remove_list_unit_chk.sv; relies on clk and arst_n in scope.
`ifndef INDEXED_INSERT_REMOVE_LIST_UNIT_MACROS_SVH
`define INDEXED_INSERT_REMOVE_LIST_UNIT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define IIRL_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define IIRL_ASSERT_NEXT(lbl, trig, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (expr)) \
		else $error(msg);

`endif

FILE: hdl/iirl_pkg.sv
// Shared constants and types for the indexed insert/remove list unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package iirl_pkg;

	// Storage dimensions.
	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;

	// Field widths fixed by the interface.
	localparam int CMD_W         = 2;
	localparam int POS_W         = 4;
	localparam int VALUE_W       = 32;
	localparam int STATUS_W      = 2;
	localparam int READ_W        = 32;
	localparam int COUNT_FIELD_W = 5;

	// Internal widths.
	localparam int COUNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W   = (COUNT_W > POS_W) ? COUNT_W : POS_W;

	// Stream data widths, padded to whole bytes.
	localparam int S_TDATA_W = ((POS_W + VALUE_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((READ_W + COUNT_FIELD_W + 7) / 8) * 8;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	// Per-cell action: hold, load, or take a neighbour's word.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FROM_LEFT,
		CELL_FROM_RIGHT
	} cell_op_t;

	// Inputs that steer one cell.
	typedef struct packed {
		cell_op_t              op;
		logic [DATA_WIDTH-1:0] word;
		logic [DATA_WIDTH-1:0] left;
		logic [DATA_WIDTH-1:0] right;
	} cell_in_t;

endpackage

FILE: hdl/indexed_insert_remove_list_unit.sv
// Indexed insert/remove list unit.
// Commands enter on the s_ stream: s_tuser carries the command (insert, remove,
// read), s_tdata the position and the word to insert. Each command gives exactly
// one result transaction on the m_ stream: m_tuser carries the status (done,
// full, out of range), m_tdata the read word and the entry count after the command.
// Every command finishes in the cycle it is accepted: the row of cells shifts up
// for an insert, down for a remove, or holds, all at that clock edge, and the read
// word is selected from the cells in that same cycle. The result appears on the m_
// side in the cycle after acceptance, and one command can be taken every cycle
// while the receiver keeps up.
// The result register parts the two sides: a new command is taken whenever that
// register is empty or is being emptied in the same cycle. When the receiver
// stalls, the result holds and no further command is taken.
// Reset (arst_n low) empties the list and drops any pending result; the stored
// words themselves are not cleared and are only read after being written.
// Depends on iirl_pkg and iirl_cell.
`timescale 1ns / 1ps

module indexed_insert_remove_list_unit
	import iirl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Command stream.
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // position[3:0], value[35:4], zero pad
	input  logic [CMD_W-1:0]     s_tuser,  // command[1:0]
	// Result stream.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // read_value[31:0], count[36:32], zero pad
	output logic [STATUS_W-1:0]  m_tuser   // status[1:0]
);

	logic                  accept;
	logic [POS_W-1:0]      pos;
	logic [CMP_W-1:0]      pos_ext;
	logic [CMP_W-1:0]      cnt_ext;
	logic [DATA_WIDTH-1:0] word;
	logic                  do_ins;
	logic                  do_rem;
	logic [STATUS_W-1:0]   status;
	logic [COUNT_W-1:0]    count_q;
	logic [COUNT_W-1:0]    count_next;
	logic [DATA_WIDTH-1:0] rd_word;
	logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
	logic                  m_tvalid_q;
	logic [STATUS_W-1:0]   status_q;
	logic [READ_W-1:0]     read_q;
	logic [COUNT_W-1:0]    count_out_q;

	// Stream handshake: take a command when the result register is free.
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign pos     = s_tdata[POS_W-1:0];
	assign word    = DATA_WIDTH'(s_tdata[POS_W +: VALUE_W]);
	assign pos_ext = CMP_W'(pos);
	assign cnt_ext = CMP_W'(count_q);

	// Command decode and bounds checks.
	always_comb begin
		status     = ST_DONE;
		do_ins     = 1'b0;
		do_rem     = 1'b0;
		count_next = count_q;
		case (s_tuser)
			CMD_INSERT: begin
				if (count_q == COUNT_W'(CAPACITY)) begin
					status = ST_FULL;
				end else if (pos_ext > cnt_ext) begin
					status = ST_RANGE;
				end else begin
					do_ins     = 1'b1;
					count_next = count_q + COUNT_W'(1);
				end
			end
			CMD_REMOVE: begin
				if (pos_ext >= cnt_ext) begin
					status = ST_RANGE;
				end else begin
					do_rem     = 1'b1;
					count_next = count_q - COUNT_W'(1);
				end
			end
			CMD_READ: begin
				if (pos_ext >= cnt_ext) begin
					status = ST_RANGE;
				end
			end
			default: begin
				status = ST_RANGE;
			end
		endcase
	end

	// Row of cells; each decides locally whether to load, shift or hold.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_in_t cin;

		always_comb begin
			cin.word  = word;
			cin.left  = (i == 0) ? word : cell_q[(i == 0) ? 0 : i - 1];
			cin.right = (i == CAPACITY - 1) ? cell_q[i]
				: cell_q[(i == CAPACITY - 1) ? i : i + 1];
			cin.op    = CELL_HOLD;
			if (accept && do_ins) begin
				if (CMP_W'(i) == pos_ext) begin
					cin.op = CELL_LOAD;
				end else if (CMP_W'(i) > pos_ext) begin
					cin.op = CELL_FROM_LEFT;
				end
			end else if (accept && do_rem) begin
				if (CMP_W'(i) >= pos_ext) begin
					cin.op = CELL_FROM_RIGHT;
				end
			end
		end

		iirl_cell u_cell (
			.clk (clk),
			.cin (cin),
			.q   (cell_q[i])
		);
	end

	// Read select: AND-OR over the cells by position.
	always_comb begin
		rd_word = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			if (CMP_W'(k) == pos_ext) begin
				rd_word = rd_word | cell_q[k];
			end
		end
	end

	// Entry count and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q    <= count_next;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status;
			count_out_q <= count_next;
			if (s_tuser == CMD_READ && status == ST_DONE) begin
				read_q <= READ_W'(rd_word);
			end else begin
				read_q <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = M_TDATA_W'({COUNT_FIELD_W'(count_out_q), read_q});

endmodule

FILE: hdl/iirl_cell.sv
// One storage cell of the list: holds a word and takes it from the new
// word or from either neighbour. Depends on iirl_pkg.
`timescale 1ns / 1ps

module iirl_cell
	import iirl_pkg::*;
(
	input  logic                  clk,
	input  cell_in_t              cin,
	output logic [DATA_WIDTH-1:0] q
);

	logic [DATA_WIDTH-1:0] word_q;

	// Shift, load or hold the stored word.
	always_ff @(posedge clk) begin
		case (cin.op)
			CELL_LOAD:       word_q <= cin.word;
			CELL_FROM_LEFT:  word_q <= cin.left;
			CELL_FROM_RIGHT: word_q <= cin.right;
			default:         word_q <= word_q;
		endcase
	end

	assign q = word_q;

endmodule

FILE: hdl/indexed_insert_remove_list_unit_chk.sv
// Port-level checker for the indexed insert/remove list unit, with its bind.
// Depends on iirl_pkg and indexed_insert_remove_list_unit_macros.svh.
`timescale 1ns / 1ps
`include "indexed_insert_remove_list_unit_macros.svh"

module indexed_insert_remove_list_unit_chk
	import iirl_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [S_TDATA_W-1:0] s_tdata,
	input logic [CMD_W-1:0]     s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [STATUS_W-1:0]  m_tuser
);

	logic [COUNT_FIELD_W-1:0] res_count;
	logic [READ_W-1:0]        res_read;

	assign res_count = m_tdata[READ_W +: COUNT_FIELD_W];
	assign res_read  = m_tdata[READ_W-1:0];

	// The list never reports more entries than it can hold.
	`IIRL_ASSERT_ALWAYS(a_count_bound,
		!m_tvalid || res_count <= COUNT_FIELD_W'(CAPACITY),
		"count above capacity")
	// A full refusal only happens when the list is at capacity.
	`IIRL_ASSERT_ALWAYS(a_full_count,
		!(m_tvalid && m_tuser == ST_FULL) || res_count == COUNT_FIELD_W'(CAPACITY),
		"full status with spare room")
	// A failed command returns no data.
	`IIRL_ASSERT_ALWAYS(a_fail_zero,
		!(m_tvalid && m_tuser != ST_DONE) || res_read == '0,
		"data on failed command")
	// Every accepted command yields a result in the next cycle.
	`IIRL_ASSERT_NEXT(a_result_follows, s_tvalid && s_tready, m_tvalid,
		"accepted command gave no result")
	// A stalled result holds its payload.
	`IIRL_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind indexed_insert_remove_list_unit indexed_insert_remove_list_unit_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
